// File: hw/rtl/dwb_pkg.sv
// dwb_pkg: shared types, constants and bit helpers for the day window bitmap
// used by dwb_mem, dwb_scan and day_window_bitmap_unit
`timescale 1ns / 1ps

package dwb_pkg;

	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;
	localparam int IX_W   = 12;
	localparam int CNT_W  = 10;
	localparam int DAY_W  = 16;
	localparam int PC_W   = 7;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_TEST = 2'd1,
		CMD_FIND = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OUTSIDE  = 2'd1,
		ST_TOO_WIDE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_SHIFT,
		S_SH_END,
		S_WR_RD,
		S_WR_WB,
		S_SCAN,
		S_SC_END,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [IX_W-1:0] find_ix;
		logic [IX_W-1:0] test_ix;
	} scan_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             any;
		logic [IX_W-1:0]  first_ix;
		logic [IX_W-1:0]  last_ix;
		logic             found;
		logic [IX_W-1:0]  found_ix;
		logic             bitv;
	} scan_res_t;

	function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] w);
		logic [PC_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			r = r + PC_W'(w[i]);
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/dwb_mem.sv
// dwb_mem: bitmap word memory, one write and one registered read per cycle
// words never written read as zero; depends on dwb_pkg
`timescale 1ns / 1ps

module dwb_mem
	import dwb_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/dwb_scan.sv
// dwb_scan: word-serial pass over the bitmap for count, first/last mark, search and test
// depends on dwb_pkg
`timescale 1ns / 1ps

module dwb_scan
	import dwb_pkg::*;
#(
	parameter int AW = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              vld,
	input  logic [AW-1:0]     widx,
	input  logic [WORD_W-1:0] rdata,
	input  scan_ctl_t         ctl,
	output scan_res_t         res
);

	scan_res_t         res_q;
	logic [IX_W-1:0]   base;
	logic [IX_W-1:0]   wi;
	logic [IX_W-1:0]   fw;
	logic [WORD_W-1:0] fmask;
	logic [WORD_W-1:0] masked;

	assign wi     = IX_W'(widx);
	assign base   = wi << BIT_W;
	assign fw     = ctl.find_ix >> BIT_W;
	assign fmask  = (wi == fw) ? ({WORD_W{1'b1}} << ctl.find_ix[BIT_W-1:0]) :
	                (wi > fw)  ? {WORD_W{1'b1}} : '0;
	assign masked = rdata & fmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clr) begin
			res_q <= '0;
		end else if (vld) begin
			res_q.cnt <= res_q.cnt + CNT_W'(popcount(rdata));
			if (rdata != '0) begin
				if (!res_q.any) begin
					res_q.first_ix <= base | IX_W'(lowest_set(rdata));
				end
				res_q.any     <= 1'b1;
				res_q.last_ix <= base | IX_W'(highest_set(rdata));
			end
			if (masked != '0 && !res_q.found) begin
				res_q.found    <= 1'b1;
				res_q.found_ix <= base | IX_W'(lowest_set(masked));
			end
			if (wi == (ctl.test_ix >> BIT_W)) begin
				res_q.bitv <= rdata[ctl.test_ix[BIT_W-1:0]];
			end
		end
	end

	assign res = res_q;

endmodule

// File: hw/rtl/day_window_bitmap_unit.sv
// day_window_bitmap_unit: top level, command sequencer and window registers
// depends on dwb_pkg, dwb_mem, dwb_scan
`timescale 1ns / 1ps

// Usage:
//   A request (command, day, new_bit) is taken at a rising edge with start high and
//   busy low. Set writes one day's bit, sliding the window start back or the end
//   forward; test reads one day; find returns the first marked day at or after day.
//   Exactly one result follows each request: done is high for one cycle with all
//   result ports valid, and the next request may be issued in that same cycle.
//   The bitmap sits in NW = ceil(BITMAP_DAYS / 64) words of 64 bits.
//   A set before the window start first shifts the bitmap words, streaming them
//   through the memory read port one word per cycle; an accepted set then reads,
//   modifies and writes back its word. Every request ends with a word-serial scan
//   that recounts the marks; one request is in flight at a time.
//   Reset clears the window and the per-word valid bits, so the bitmap reads as
//   empty at once with no clearing pass.
//   Results cannot be held off; done marks them for one cycle.
module day_window_bitmap_unit
	import dwb_pkg::*;
#(
	parameter int BITMAP_DAYS = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       command,
	input  logic [DAY_W-1:0] day,
	input  logic             new_bit,
	output logic             done,
	output logic             bit_value,
	output logic             found,
	output logic [DAY_W-1:0] found_day,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] marked_count,
	output logic             any_marked,
	output logic [DAY_W-1:0] first_marked_day,
	output logic [DAY_W-1:0] last_marked_day,
	output logic [DAY_W-1:0] window_start,
	output logic [DAY_W-1:0] window_end
);

	localparam int NW = (BITMAP_DAYS + WORD_W - 1) / WORD_W;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int SW = AW + 2;

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [DAY_W-1:0]  day_q;
	logic              nb_q;
	status_t           status_q;
	logic [DAY_W-1:0]  start_q, end_q;
	logic              open_q;
	logic [AW:0]       n_q;
	logic signed [SW-1:0] src_q;
	logic [AW-1:0]     k_q;
	logic [BIT_W-1:0]  db_q;
	logic [WORD_W-1:0] hi_q;
	logic              hi_ok_q;
	logic              sh_v_s1, sh_z_s1;
	logic              sc_v_s1;
	logic [AW-1:0]     sc_idx_s1;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	logic [WORD_W-1:0] lo_w, sh_word;

	logic [DAY_W:0]    span_lo, span_hi;
	logic [DAY_W-1:0]  back_gap, off;
	logic [AW-1:0]     dw;
	logic              test_ok, find_ok;
	scan_ctl_t         sctl;
	scan_res_t         sres;

	logic              done_q, bitv_q, found_q, any_q;
	logic [DAY_W-1:0]  fday_q, first_q, last_q;
	logic [1:0]        stat_q;
	logic [CNT_W-1:0]  cnt_q;

	assign span_lo  = {1'b0, end_q} - {1'b0, day_q};
	assign span_hi  = {1'b0, day_q} - {1'b0, start_q};
	assign back_gap = start_q - day_q;
	assign dw       = AW'(back_gap >> BIT_W);
	assign off      = day_q - start_q;
	assign test_ok  = open_q && day_q >= start_q && day_q <= end_q;
	assign find_ok  = open_q && day_q <= end_q;

	assign sctl.test_ix = IX_W'(off);
	assign sctl.find_ix = (day_q <= start_q) ? '0 : IX_W'(off);

	assign lo_w    = sh_z_s1 ? '0 : mem_rdata;
	assign sh_word = (db_q == '0) ? hi_q :
	                 ((hi_q << db_q) | (lo_w >> (7'd64 - {1'b0, db_q})));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = sh_word;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_SCAN;
				if (cmd_q == CMD_SET) begin
					if (!open_q) begin
						state_d = S_WR_RD;
					end else if (day_q < start_q) begin
						if (span_lo < (DAY_W+1)'(BITMAP_DAYS)) state_d = S_SHIFT;
					end else if (day_q > end_q) begin
						if (span_hi < (DAY_W+1)'(BITMAP_DAYS)) state_d = S_WR_RD;
					end else begin
						state_d = S_WR_RD;
					end
				end
			end
			S_SHIFT: begin
				mem_raddr = src_q[AW-1:0];
				if (n_q == (AW+1)'(NW)) state_d = S_SH_END;
			end
			S_SH_END: state_d = S_WR_RD;
			S_WR_RD: begin
				mem_raddr = AW'(off >> BIT_W);
				state_d   = S_WR_WB;
			end
			S_WR_WB: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				mem_raddr = n_q[AW-1:0];
				if (n_q == (AW+1)'(NW - 1)) state_d = S_SC_END;
			end
			S_SC_END: state_d = S_OUT;
			S_OUT:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
		if (sh_v_s1 && hi_ok_q) begin
			mem_we = 1'b1;
		end
		if (state_q == S_WR_WB) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(off >> BIT_W);
			mem_wdata = (mem_rdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << off[BIT_W-1:0]))
			          | ({{(WORD_W-1){1'b0}}, nb_q} << off[BIT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			end_q     <= '0;
			open_q    <= 1'b0;
			cmd_q     <= CMD_NOP;
			day_q     <= '0;
			nb_q      <= 1'b0;
			status_q  <= ST_OK;
			n_q       <= '0;
			src_q     <= '0;
			k_q       <= '0;
			db_q      <= '0;
			hi_q      <= '0;
			hi_ok_q   <= 1'b0;
			sh_v_s1   <= 1'b0;
			sh_z_s1   <= 1'b0;
			sc_v_s1   <= 1'b0;
			sc_idx_s1 <= '0;
			done_q    <= 1'b0;
			bitv_q    <= 1'b0;
			found_q   <= 1'b0;
			fday_q    <= '0;
			stat_q    <= '0;
			cnt_q     <= '0;
			any_q     <= 1'b0;
			first_q   <= '0;
			last_q    <= '0;
		end else begin
			sh_v_s1   <= (state_q == S_SHIFT);
			sh_z_s1   <= src_q < 0;
			sc_v_s1   <= (state_q == S_SCAN);
			sc_idx_s1 <= n_q[AW-1:0];
			done_q    <= (state_q == S_OUT);
			if (sh_v_s1) begin
				hi_q    <= lo_w;
				hi_ok_q <= 1'b1;
				if (hi_ok_q) k_q <= k_q - AW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd_t'(command);
						day_q <= day;
						nb_q  <= new_bit;
					end
				end
				S_DEC: begin
					status_q <= ST_OK;
					n_q      <= '0;
					hi_ok_q  <= 1'b0;
					k_q      <= AW'(NW - 1);
					src_q    <= SW'(NW - 1) - SW'(dw);
					db_q     <= back_gap[BIT_W-1:0];
					case (cmd_q)
						CMD_SET: begin
							if (!open_q) begin
								start_q <= day_q;
								end_q   <= day_q;
								open_q  <= 1'b1;
							end else if (day_q < start_q) begin
								if (span_lo < (DAY_W+1)'(BITMAP_DAYS)) start_q <= day_q;
								else status_q <= ST_TOO_WIDE;
							end else if (day_q > end_q) begin
								if (span_hi < (DAY_W+1)'(BITMAP_DAYS)) end_q <= day_q;
								else status_q <= ST_TOO_WIDE;
							end
						end
						CMD_TEST: begin
							if (!test_ok) status_q <= ST_OUTSIDE;
						end
						default: ;
					endcase
				end
				S_SHIFT: begin
					src_q <= src_q - SW'(1);
					n_q   <= n_q + (AW+1)'(1);
				end
				S_WR_WB: n_q <= '0;
				S_SCAN:  n_q <= n_q + (AW+1)'(1);
				S_OUT: begin
					bitv_q  <= (cmd_q == CMD_TEST) && test_ok && sres.bitv;
					found_q <= (cmd_q == CMD_FIND) && find_ok && sres.found;
					fday_q  <= ((cmd_q == CMD_FIND) && find_ok && sres.found) ?
					           start_q + DAY_W'(sres.found_ix) : '0;
					stat_q  <= status_q;
					cnt_q   <= sres.cnt;
					any_q   <= sres.any;
					first_q <= sres.any ? start_q + DAY_W'(sres.first_ix) : '0;
					last_q  <= sres.any ? start_q + DAY_W'(sres.last_ix) : '0;
				end
				default: ;
			endcase
		end
	end

	dwb_mem #(
		.DEPTH (NW),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dwb_scan #(
		.AW(AW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (state_q == S_SCAN && n_q == '0),
		.vld   (sc_v_s1),
		.widx  (sc_idx_s1),
		.rdata (mem_rdata),
		.ctl   (sctl),
		.res   (sres)
	);

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign bit_value        = bitv_q;
	assign found            = found_q;
	assign found_day        = fday_q;
	assign status           = stat_q;
	assign marked_count     = cnt_q;
	assign any_marked       = any_q;
	assign first_marked_day = first_q;
	assign last_marked_day  = last_q;
	assign window_start     = start_q;
	assign window_end       = end_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SHIFT || state_q == S_SH_END || state_q == S_WR_WB))
		else $error("memory write outside shift or write-back");

	a_busy_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a request");

	a_found_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (found_day >= window_start && found_day <= window_end))
		else $error("found day outside window");
`endif

endmodule

// File: dv/tb_day_window_bitmap_unit.sv
// tb_day_window_bitmap_unit: self-checking bench for the day window bitmap unit
// drives set, test, find and no-op requests, predicts each result in a local model
// depends on dwb_pkg and day_window_bitmap_unit
`timescale 1ns / 1ps

module tb_day_window_bitmap_unit;
	import dwb_pkg::*;

	localparam int DAYS = 512;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic             bitv;
		logic             fnd;
		logic [DAY_W-1:0] fday;
		logic [1:0]       stat;
		logic [CNT_W-1:0] cnt;
		logic             any;
		logic [DAY_W-1:0] first;
		logic [DAY_W-1:0] last;
		logic [DAY_W-1:0] wstart;
		logic [DAY_W-1:0] wend;
	} day_result_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       command;
	logic [DAY_W-1:0] day;
	logic             new_bit;
	logic             done;
	logic             bit_value;
	logic             found;
	logic [DAY_W-1:0] found_day;
	logic [1:0]       status;
	logic [CNT_W-1:0] marked_count;
	logic             any_marked;
	logic [DAY_W-1:0] first_marked_day;
	logic [DAY_W-1:0] last_marked_day;
	logic [DAY_W-1:0] window_start;
	logic [DAY_W-1:0] window_end;

	bit          marks[DAYS];
	int unsigned win_lo;
	int unsigned win_hi;
	bit          win_open;
	day_result_t pending_results[$];
	int          fail_count;
	int          idle_cycles;
	int          sent_count;
	int          checked_count;
	int          too_wide_count;
	int          outside_count;

	day_window_bitmap_unit #(.BITMAP_DAYS(DAYS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .day(day), .new_bit(new_bit), .done(done),
		.bit_value(bit_value), .found(found), .found_day(found_day),
		.status(status), .marked_count(marked_count), .any_marked(any_marked),
		.first_marked_day(first_marked_day), .last_marked_day(last_marked_day),
		.window_start(window_start), .window_end(window_end)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic day_result_t predict_day_request(cmd_t cmd, int unsigned d, bit nb);
		day_result_t r;
		int unsigned len;
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned i;
		bit stop;
		r = '{default: '0};
		stop = 1'b0;
		if (cmd == CMD_SET) begin
			if (!win_open) begin
				foreach (marks[k]) marks[k] = 1'b0;
				win_lo = d;
				win_hi = d;
				win_open = 1'b1;
			end else if (d < win_lo) begin
				if (win_hi - d >= DAYS) begin
					r.stat = ST_TOO_WIDE;
					stop = 1'b1;
				end else begin
					for (int k = DAYS - 1; k >= 0; k--)
						marks[k] = (k >= win_lo - d) ? marks[k - (win_lo - d)] : 1'b0;
					win_lo = d;
				end
			end else if (d > win_hi) begin
				if (d - win_lo >= DAYS) begin
					r.stat = ST_TOO_WIDE;
					stop = 1'b1;
				end else begin
					win_hi = d;
				end
			end
			if (!stop)
				marks[d - win_lo] = nb;
		end else if (cmd == CMD_TEST) begin
			if (win_open && d >= win_lo && d <= win_hi)
				r.bitv = marks[d - win_lo];
			else
				r.stat = ST_OUTSIDE;
		end else if (cmd == CMD_FIND) begin
			if (win_open && d <= win_hi) begin
				len = win_hi - win_lo + 1;
				for (i = (d <= win_lo) ? 0 : d - win_lo; i < len && i < DAYS; i++) begin
					if (marks[i]) begin
						r.fnd = 1'b1;
						r.fday = DAY_W'(win_lo + i);
						break;
					end
				end
			end
		end
		len = win_open ? win_hi - win_lo + 1 : 0;
		n = 0;
		lo = 0;
		hi = 0;
		for (i = 0; i < len && i < DAYS; i++) begin
			if (marks[i]) begin
				if (n == 0) lo = i;
				hi = i;
				n++;
			end
		end
		r.cnt = CNT_W'(n);
		r.any = n != 0;
		r.first = (n != 0) ? DAY_W'(win_lo + lo) : '0;
		r.last = (n != 0) ? DAY_W'(win_lo + hi) : '0;
		r.wstart = DAY_W'(win_lo);
		r.wend = DAY_W'(win_hi);
		return r;
	endfunction

	task automatic send_day_request(cmd_t cmd, int unsigned d, bit nb);
		int gap;
		day_result_t exp_r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			command <= cmd_t'($urandom_range(0, 3));
			day <= DAY_W'($urandom);
			new_bit <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		day <= DAY_W'(d);
		new_bit <= nb;
		do @(posedge clk); while (busy);
		exp_r = predict_day_request(cmd, d, nb);
		pending_results = {pending_results, exp_r};
		sent_count++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			day_result_t e;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				checked_count++;
				if (e.stat == ST_TOO_WIDE) too_wide_count++;
				if (e.stat == ST_OUTSIDE) outside_count++;
				if (bit_value !== e.bitv) begin
					$error("bit_value exp %0h got %0h", e.bitv, bit_value); fail_count++;
				end
				if (found !== e.fnd) begin
					$error("found exp %0h got %0h", e.fnd, found); fail_count++;
				end
				if (found_day !== e.fday) begin
					$error("found_day exp %0d got %0d", e.fday, found_day); fail_count++;
				end
				if (status !== e.stat) begin
					$error("status exp %0d got %0d", e.stat, status); fail_count++;
				end
				if (marked_count !== e.cnt) begin
					$error("marked_count exp %0d got %0d", e.cnt, marked_count); fail_count++;
				end
				if (any_marked !== e.any) begin
					$error("any_marked exp %0h got %0h", e.any, any_marked); fail_count++;
				end
				if (first_marked_day !== e.first) begin
					$error("first_marked_day exp %0d got %0d", e.first, first_marked_day);
					fail_count++;
				end
				if (last_marked_day !== e.last) begin
					$error("last_marked_day exp %0d got %0d", e.last, last_marked_day);
					fail_count++;
				end
				if (window_start !== e.wstart) begin
					$error("window_start exp %0d got %0d", e.wstart, window_start); fail_count++;
				end
				if (window_end !== e.wend) begin
					$error("window_end exp %0d got %0d", e.wend, window_end); fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without progress
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_day_window_bitmap_unit: FAIL");
			$finish;
		end
	end

	task automatic test_empty_store();
		send_day_request(CMD_TEST, 0, 1'b0);
		send_day_request(CMD_FIND, 0, 1'b0);
		send_day_request(CMD_NOP, 16'hffff, 1'b1);
		send_day_request(CMD_SET, 1000, 1'b0);
		send_day_request(CMD_SET, 1000, 1'b1);
	endtask

	task automatic test_window_edges();
		send_day_request(CMD_SET, 1000 + DAYS - 1, 1'b1);
		send_day_request(CMD_SET, 1000 + DAYS, 1'b1);
		send_day_request(CMD_SET, 999, 1'b1);
		send_day_request(CMD_TEST, 999, 1'b0);
		send_day_request(CMD_TEST, 1000 + DAYS, 1'b0);
		send_day_request(CMD_FIND, 0, 1'b0);
		send_day_request(CMD_FIND, 1001, 1'b0);
		send_day_request(CMD_FIND, 1000 + DAYS, 1'b0);
		send_day_request(CMD_SET, 1000, 1'b0);
		send_day_request(CMD_SET, 1000 + DAYS - 1, 1'b0);
		send_day_request(CMD_SET, 999, 1'b0);
		send_day_request(CMD_FIND, 999, 1'b0);
	endtask

	task automatic test_low_high_days();
		send_day_request(CMD_SET, 65535, 1'b1);
		send_day_request(CMD_SET, 65535 - DAYS + 1, 1'b1);
		send_day_request(CMD_SET, 0, 1'b1);
		send_day_request(CMD_TEST, 65535, 1'b0);
		send_day_request(CMD_FIND, 65000, 1'b0);
	endtask

	// mostly days near the window, some far away
	task automatic test_random_traffic(int count);
		int unsigned d;
		int unsigned base;
		for (int k = 0; k < count; k++) begin
			base = win_open ? win_lo : 30000;
			case ($urandom_range(0, 9))
				0: d = $urandom_range(0, 65535);
				1: d = (base >= 600) ? base - $urandom_range(0, 600) : $urandom_range(0, 600);
				default: d = (base >= 40) ? base - 40 + $urandom_range(0, DAYS + 40)
					: $urandom_range(0, DAYS);
			endcase
			if (d > 65535) d = 65535;
			send_day_request(cmd_t'($urandom_range(0, 9) < 4 ? CMD_SET
				: $urandom_range(1, 3)), d, ($urandom_range(0, 3) != 0));
		end
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		sent_count = 0;
		checked_count = 0;
		too_wide_count = 0;
		outside_count = 0;
		win_lo = 0;
		win_hi = 0;
		win_open = 1'b0;
		foreach (marks[k]) marks[k] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_SET;
		day = '0;
		new_bit = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_empty_store();
		test_window_edges();
		test_low_high_days();
		test_random_traffic(630);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d rejected sets, %0d outside tests",
			sent_count, checked_count, too_wide_count, outside_count);
		if (fail_count == 0)
			$display("tb_day_window_bitmap_unit: PASS");
		else
			$display("tb_day_window_bitmap_unit: FAIL");
		$finish;
	end

endmodule
